@@ rtl/fxd_pkg.sv @@
// ----------------------------------------------------------------------------
// fxd_pkg
// shared constants, types and helpers of the fixed-point to decimal text block
// ----------------------------------------------------------------------------
`default_nettype none

package fxd_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int VALUE_W         = 48;
	localparam int IPART_W         = VALUE_W - FRAC_BITS + 1;
	localparam int MAX_INT_PLACES  = 16;
	localparam int MAX_FRAC_DIGITS = 8;
	localparam int INT_DIGITS      = 10;
	localparam int FRAC_DIGITS_W   = 10;
	localparam int TF_W            = 30;
	localparam int POW_W           = 54;
	localparam int DD_STEPS        = IPART_W;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_BIG_X = 8'h58;
	localparam logic [7:0] CH_SML_X = 8'h78;

	localparam logic [POW_W-1:0] POW10_TAB [MAX_INT_PLACES+1] = '{
		54'd1, 54'd10, 54'd100, 54'd1000, 54'd10000, 54'd100000, 54'd1000000,
		54'd10000000, 54'd100000000, 54'd1000000000, 54'd10000000000,
		54'd100000000000, 54'd1000000000000, 54'd10000000000000,
		54'd100000000000000, 54'd1000000000000000, 54'd10000000000000000
	};

	typedef enum logic [1:0] {
		REG_INT_LEN  = 2'd0,
		REG_DEC_LEN  = 2'd1,
		REG_PLUS     = 2'd2,
		REG_FILL     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [4:0] int_len;
		logic [3:0] dec_len;
		logic       plus_sign;
		logic [8:0] fill_char;
	} cfg_t;

	typedef struct packed {
		logic                      neg;
		logic                      oor;
		logic [4*INT_DIGITS-1:0]   idig;
		logic [4*MAX_FRAC_DIGITS-1:0] fdig;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// table lookup, saturates above the largest place count
	function automatic logic [POW_W-1:0] pow10(input logic [4:0] n);
		logic [POW_W-1:0] p;
		p = '1;
		for (int i = 0; i <= MAX_INT_PLACES; i++) begin
			if (n == 5'(i)) begin
				p = POW10_TAB[i];
			end
		end
		return p;
	endfunction

	function automatic logic [4*FRAC_DIGITS_W-1:0] dd_adj(input logic [4*FRAC_DIGITS_W-1:0] b);
		logic [4*FRAC_DIGITS_W-1:0] r;
		r = b;
		for (int i = 0; i < FRAC_DIGITS_W; i++) begin
			if (b[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = b[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/fxd_ifs.sv @@
// ----------------------------------------------------------------------------
// fxd channel interfaces
// valid/ready channels for input values and output characters
// ----------------------------------------------------------------------------
`default_nettype none

interface fxd_in_if;
	logic        valid;
	logic        ready;
	logic [47:0] value;
	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface fxd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;
	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/fxd_front.sv @@
// ----------------------------------------------------------------------------
// fxd_front
// takes values, rounds, range-checks and converts both parts to bcd
// ----------------------------------------------------------------------------
`default_nettype none

module fxd_front import fxd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	fxd_in_if.sink      din,
	output entry_t      push_data,
	output logic        push,
	input  wire q_stat_t q_stat
);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MUL  = 5'b00010,
		F_CMP  = 5'b00100,
		F_CNV  = 5'b01000,
		F_PUSH = 5'b10000
	} fstate_t;

	fstate_t                   state_q;
	logic                      neg_q;
	logic [IPART_W-1:0]        ip_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic [TF_W-1:0]           tf_q;
	logic                      oor_q;
	logic [DD_STEPS-1:0]       fsh_q;
	logic [4*FRAC_DIGITS_W-1:0] ibcd_q;
	logic [4*FRAC_DIGITS_W-1:0] fbcd_q;
	logic [5:0]                cnt_q;

	logic [VALUE_W-1:0]        mag;
	logic [TF_W-1:0]           p10f;
	logic [TF_W+FRAC_BITS-1:0] prod;
	logic                      carry;
	logic [IPART_W-1:0]        ipn;
	logic [4:0]                places;
	logic [4*FRAC_DIGITS_W-1:0] ibcd_adj;
	logic [4*FRAC_DIGITS_W-1:0] fbcd_adj;

	assign din.ready = (state_q == F_IDLE);
	assign mag       = din.value[VALUE_W-1] ? VALUE_W'(-din.value) : din.value;
	assign p10f      = TF_W'(pow10(5'(cfg.dec_len) + 5'd1));
	assign prod      = (TF_W+FRAC_BITS)'(frac_q) * (TF_W+FRAC_BITS)'(p10f);
	assign carry     = (tf_q >= p10f - TF_W'(5));
	assign ipn       = ip_q + IPART_W'(carry);
	assign places    = cfg.int_len - 5'(neg_q || cfg.plus_sign);
	assign ibcd_adj  = dd_adj(ibcd_q);
	assign fbcd_adj  = dd_adj(fbcd_q);

	assign push = (state_q == F_PUSH) && !q_stat.full;
	assign push_data.neg  = neg_q;
	assign push_data.oor  = oor_q;
	assign push_data.idig = ibcd_q;
	assign push_data.fdig = fbcd_q[4 +: 4*MAX_FRAC_DIGITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (din.valid) state_q <= F_MUL;
				F_MUL:  state_q <= F_CMP;
				F_CMP:  state_q <= F_CNV;
				F_CNV:  if (cnt_q == 6'(DD_STEPS - 1)) state_q <= F_PUSH;
				F_PUSH: if (!q_stat.full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				neg_q  <= din.value[VALUE_W-1];
				ip_q   <= IPART_W'(mag[VALUE_W-1:FRAC_BITS]);
				frac_q <= mag[FRAC_BITS-1:0];
			end
			F_MUL: begin
				tf_q <= prod[TF_W+FRAC_BITS-1:FRAC_BITS];
			end
			F_CMP: begin
				ip_q   <= ipn;
				oor_q  <= (POW_W'(ipn) >= pow10(places));
				fsh_q  <= DD_STEPS'(tf_q + TF_W'(5));
				ibcd_q <= '0;
				fbcd_q <= '0;
				cnt_q  <= '0;
			end
			F_CNV: begin
				ibcd_q <= {ibcd_adj[4*FRAC_DIGITS_W-2:0], ip_q[IPART_W-1]};
				fbcd_q <= {fbcd_adj[4*FRAC_DIGITS_W-2:0], fsh_q[DD_STEPS-1]};
				ip_q   <= {ip_q[IPART_W-2:0], 1'b0};
				fsh_q  <= {fsh_q[DD_STEPS-2:0], 1'b0};
				cnt_q  <= cnt_q + 6'd1;
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/fxd_queue.sv @@
// ----------------------------------------------------------------------------
// fxd_queue
// two-entry queue of converted items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fxd_queue import fxd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_data,
	input  wire logic   pop,
	output entry_t      head,
	output q_stat_t     stat
);

	entry_t     mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head       = mem_q[rp_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ rtl/fxd_back.sv @@
// ----------------------------------------------------------------------------
// fxd_back
// walks one converted item and sends its text one character a beat
// ----------------------------------------------------------------------------
`default_nettype none

module fxd_back import fxd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire entry_t  head,
	input  wire q_stat_t q_stat,
	output logic         pop,
	fxd_out_if.source    dout
);

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b00000001,
		PH_SIGN  = 8'b00000010,
		PH_INT   = 8'b00000100,
		PH_MINUS = 8'b00001000,
		PH_POINT = 8'b00010000,
		PH_FRAC  = 8'b00100000,
		PH_XS    = 8'b01000000,
		PH_NUL   = 8'b10000000
	} phase_t;

	phase_t     ph_q, ph_n;
	logic [4:0] k_q, k_n;
	logic       st_q, st_n;
	logic       pd_q, pd_n;
	logic       ov_q;
	logic [7:0] ch_q;
	logic       last_q;

	logic       can_load, emit, lst, bad_len;
	logic [7:0] ch;
	logic [4:0] places, xs;
	logic [3:0] ipos, dig;
	logic [2:0] fpos;
	logic [3:0] fd;

	assign can_load = !ov_q || dout.ready;
	assign bad_len  = (cfg.int_len == 5'd0) || (cfg.int_len > 5'(MAX_INT_PLACES));
	assign places   = cfg.int_len - 5'(head.neg || cfg.plus_sign);
	assign xs       = head.neg ? cfg.int_len - 5'd1 : cfg.int_len;
	assign ipos     = 4'(places - 5'd1 - k_q);
	assign dig      = (ipos < 4'(INT_DIGITS)) ? head.idig[4*ipos +: 4] : 4'd0;
	assign fpos     = 3'(cfg.dec_len - 4'd1 - 4'(k_q));
	assign fd       = head.fdig[4*fpos +: 4];

	assign dout.valid     = ov_q;
	assign dout.char_code = ch_q;
	assign dout.last      = last_q;

	always_comb begin
		ph_n = ph_q;
		k_n  = k_q;
		st_n = st_q;
		pd_n = pd_q;
		emit = 1'b0;
		ch   = CH_NUL;
		lst  = 1'b0;
		pop  = 1'b0;
		if (ph_q == PH_IDLE) begin
			if (!q_stat.empty) begin
				k_n = '0;
				if (bad_len) ph_n = PH_NUL;
				else if (head.oor) ph_n = PH_XS;
				else ph_n = PH_SIGN;
			end
		end else if (can_load) begin
			unique case (ph_q)
				PH_SIGN: begin
					emit = !head.neg && cfg.plus_sign;
					ch   = CH_PLUS;
					ph_n = PH_INT;
					k_n  = '0;
					st_n = 1'b0;
					pd_n = head.neg;
				end
				PH_INT: begin
					if (k_q == places) begin
						ph_n = PH_MINUS;
					end else if (dig != 4'd0 || st_q || ipos == 4'd0) begin
						emit = 1'b1;
						if (pd_q) begin
							ch   = CH_MINUS;
							pd_n = 1'b0;
						end else begin
							ch   = CH_ZERO + 8'(dig);
							st_n = 1'b1;
							k_n  = k_q + 5'd1;
						end
					end else begin
						emit = !cfg.fill_char[8];
						ch   = cfg.fill_char[7:0];
						k_n  = k_q + 5'd1;
					end
				end
				PH_MINUS: begin
					emit = pd_q;
					ch   = CH_MINUS;
					ph_n = PH_POINT;
				end
				PH_POINT: begin
					k_n = '0;
					if (cfg.dec_len == 4'd0) begin
						ph_n = PH_NUL;
					end else begin
						emit = 1'b1;
						ch   = CH_POINT;
						ph_n = PH_FRAC;
					end
				end
				PH_FRAC: begin
					if (k_q == 5'(cfg.dec_len)) begin
						ph_n = PH_NUL;
					end else begin
						emit = 1'b1;
						ch   = head.oor ? CH_SML_X : CH_ZERO + 8'(fd);
						k_n  = k_q + 5'd1;
					end
				end
				PH_XS: begin
					if (k_q == xs) begin
						ph_n = PH_POINT;
					end else begin
						emit = 1'b1;
						ch   = CH_BIG_X;
						k_n  = k_q + 5'd1;
					end
				end
				PH_NUL: begin
					emit = 1'b1;
					ch   = CH_NUL;
					lst  = 1'b1;
					pop  = 1'b1;
					ph_n = PH_IDLE;
				end
				default: ph_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			ov_q <= 1'b0;
			k_q  <= '0;
			st_q <= 1'b0;
			pd_q <= 1'b0;
		end else begin
			ph_q <= ph_n;
			k_q  <= k_n;
			st_q <= st_n;
			pd_q <= pd_n;
			if (can_load) ov_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && emit) begin
			ch_q   <= ch;
			last_q <= lst;
		end
	end

endmodule

`default_nettype wire

@@ rtl/fixed_to_decimal_text.sv @@
// ----------------------------------------------------------------------------
// fixed_to_decimal_text
// formats signed q31.16 values as fixed-width decimal text unless fill is suppressed, one char a beat
// ----------------------------------------------------------------------------
//  channel  dir  beat                      accepted when
//  din      in   value[47:0]               valid && ready
//  dout     out  char_code[7:0], last      valid && ready
//  apb      in   paddr[3:0], pwdata[31:0]  psel && penable && pwrite
//
//  front: one value at a time (accept, multiply, round, 33-step bcd conversion, push)
//  back: one char per cycle while dout is ready, plus phase steps per item that send nothing,
//  and a step per leading place when fill is suppressed
//  while dout is ready, sustained rate is set by the front conversion loop
//  a two-entry queue lets front and back stall on their own
//  reset is asynchronous and clears control state only
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_to_decimal_text import fxd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	fxd_in_if.sink           din,
	fxd_out_if.source        dout,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [4:0] int_len_q;
	logic [3:0] dec_len_q;
	logic       plus_q;
	logic [8:0] fill_q;
	cfg_t       cfg;
	entry_t     push_data, head;
	logic       push, pop, wr_en;
	q_stat_t    q_stat;
	reg_idx_t   ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_len_q <= 5'd8;
			dec_len_q <= 4'd0;
			plus_q    <= 1'b0;
			fill_q    <= 9'd32;
		end else if (wr_en) begin
			unique case (ridx)
				REG_INT_LEN: int_len_q <= pwdata[4:0];
				REG_DEC_LEN: dec_len_q <= pwdata[3:0];
				REG_PLUS:    plus_q    <= pwdata[0];
				REG_FILL:    fill_q    <= pwdata[8:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_INT_LEN: prdata = 32'(int_len_q);
			REG_DEC_LEN: prdata = 32'(dec_len_q);
			REG_PLUS:    prdata = 32'(plus_q);
			REG_FILL:    prdata = 32'(fill_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.int_len   = int_len_q;
	assign cfg.dec_len   = (dec_len_q > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS) : dec_len_q;
	assign cfg.plus_sign = plus_q;
	assign cfg.fill_char = fill_q;

	fxd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.din       (din),
		.push_data (push_data),
		.push      (push),
		.q_stat    (q_stat)
	);

	fxd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	fxd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.dout   (dout)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full && !pop))
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue pop while empty");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> dout.valid && dout.last)
		else $error("item retired without terminator beat");

endmodule

`default_nettype wire
